// ===== src/rarlg_pkg.sv =====
`timescale 1ns / 1ps

package rarlg_pkg;

    // Word width of the ring and of the result fields
    localparam int DATA_W = 32;
    localparam int FRAC_W = 23;

    // Ring geometry
    localparam int RING_DEPTH_C = 17;
    localparam int LEAD_START   = 0;
    localparam int LAG_START    = 10;

    // Rotation amounts for the lag and lead words
    localparam int ROT_LAG  = 13;
    localparam int ROT_LEAD = 9;

    // Congruential fill: s = s * LCG_MULT + LCG_INC
    localparam logic [DATA_W-1:0] LCG_MULT   = 32'd2891336453;
    localparam logic [DATA_W-1:0] LCG_INC    = 32'd1;
    localparam logic [DATA_W-1:0] SEED_RESET = 32'd1;

    // Item codes
    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    // Rotate a word left by a fixed amount
    function automatic logic [DATA_W-1:0] rot_left(input logic [DATA_W-1:0] x, input int k);
        logic [2*DATA_W-1:0] both;
        both = {x, x} << k;
        return both[2*DATA_W-1:DATA_W];
    endfunction

endpackage

// ===== src/rarlg_ring.sv =====
`timescale 1ns / 1ps

module rarlg_ring
    import rarlg_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_C
)
(
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(RING_DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]             wr_data,
    input  logic [$clog2(RING_DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(RING_DEPTH)-1:0] rd_addr_b,
    output logic [DATA_W-1:0]             rd_data_a,
    output logic [DATA_W-1:0]             rd_data_b
);

    logic [DATA_W-1:0] mem [RING_DEPTH];

    // Write one word per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read two words, registered
    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== src/rarlg_div.sv =====
`timescale 1ns / 1ps

module rarlg_div
    import rarlg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] dvd_reg;
    logic [DATA_W-1:0] dsr_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, dvd_reg[DATA_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    // Sequence the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Hold operands and the partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DATA_W-2:0], 1'b0};
            if (!diff[DATA_W])
            begin
                rem_reg <= diff[DATA_W-1:0];
            end
            else
            begin
                rem_reg <= trial[DATA_W-1:0];
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== src/rotate_add_lagged_random_generator_unit.sv =====
`timescale 1ns / 1ps

// Lagged rotate-and-add random generator over a 17-word ring.
// Input channel (in_valid / in_stall) carries op and limit: op 0 draws one
// word, op 1 refills the ring from the seed register and gives no result.
// Output channel (out_valid / out_stall) carries random_word, fraction
// (top 23 bits of the word) and reduced (word modulo limit, or the word
// itself for a zero limit). The seed register is written through cfg_write
// and cfg_data and takes effect at the next refill.
// A draw reads both ring words in the accept cycle, computes and writes
// back the new word in the next cycle, then runs a bit-serial remainder
// unit when limit is non-zero (with a zero limit it is skipped). The result
// then passes through the hold state to the output register, and only after
// that is the next item taken. A refill walks the ring one word per cycle.
// The single write port of the ring and the remainder unit set this pace.
// After reset the ring is filled from seed 1, during which in_stall is
// high; configuration writes are taken throughout.
// A finished word waits in the output register while out_stall is high;
// the next item is accepted meanwhile, and its result waits behind it.
module rotate_add_lagged_random_generator_unit
    import rarlg_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_C
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              op,
    input  logic [DATA_W-1:0] limit,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] random_word,
    output logic [FRAC_W-1:0] fraction,
    output logic [DATA_W-1:0] reduced,
    input  logic              cfg_write,
    input  logic [DATA_W-1:0] cfg_data
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_CALC,
        S_DIV,
        S_HOLD
    } state_t;

    state_t            state_reg;
    logic [PTR_W-1:0]  fill_idx_reg;
    logic [PTR_W-1:0]  lead_reg;
    logic [PTR_W-1:0]  lag_reg;
    logic [DATA_W-1:0] lcg_reg;
    logic [DATA_W-1:0] seed_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] limit_reg;
    logic [DATA_W-1:0] word_reg;
    logic [DATA_W-1:0] red_reg;
    logic [DATA_W-1:0] random_word_reg;
    logic [DATA_W-1:0] reduced_reg;

    logic [DATA_W-1:0] lcg_prod;
    logic [DATA_W-1:0] lcg_next;
    logic [DATA_W-1:0] lead_word;
    logic [DATA_W-1:0] lag_word;
    logic [DATA_W-1:0] word_calc;
    logic              in_accept;
    logic              out_free;
    logic              ring_we;
    logic [PTR_W-1:0]  ring_waddr;
    logic [DATA_W-1:0] ring_wdata;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_rem;
    logic [PTR_W-1:0]  lead_down;
    logic [PTR_W-1:0]  lag_down;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    // Next congruential word for the fill
    assign lcg_prod = lcg_reg * LCG_MULT;
    assign lcg_next = lcg_prod + LCG_INC;

    // New ring word from the two registered reads
    assign word_calc = rot_left(lag_word, ROT_LAG) + rot_left(lead_word, ROT_LEAD);

    // Step both pointers down, wrapping at zero
    assign lead_down = (lead_reg == '0) ? PTR_LAST : lead_reg - 1'b1;
    assign lag_down  = (lag_reg == '0) ? PTR_LAST : lag_reg - 1'b1;

    // Write port: fill word or the drawn word at the lead pointer
    assign ring_we    = (state_reg == S_FILL) || (state_reg == S_CALC);
    assign ring_waddr = (state_reg == S_FILL) ? fill_idx_reg : lead_reg;
    assign ring_wdata = (state_reg == S_FILL) ? lcg_next : word_calc;

    assign div_start = (state_reg == S_CALC) && (limit_reg != '0);

    rarlg_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .clk       (clk),
        .wr_en     (ring_we),
        .wr_addr   (ring_waddr),
        .wr_data   (ring_wdata),
        .rd_addr_a (lead_reg),
        .rd_addr_b (lag_reg),
        .rd_data_a (lead_word),
        .rd_data_b (lag_word)
    );

    rarlg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (word_calc),
        .divisor   (limit_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Hold the seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
        end
        else if (cfg_write)
        begin
            seed_reg <= cfg_data;
        end
    end

    // Sequence fill, draw and output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            fill_idx_reg  <= '0;
            lcg_reg       <= SEED_RESET;
            lead_reg      <= PTR_W'(LEAD_START);
            lag_reg       <= PTR_W'(LAG_START);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Drop the output word once taken, unless a finished draw replaces it
            if (out_valid_reg && !out_stall && (state_reg != S_HOLD))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_FILL:
                begin
                    lcg_reg      <= lcg_next;
                    fill_idx_reg <= fill_idx_reg + 1'b1;
                    if (fill_idx_reg == PTR_LAST)
                    begin
                        lead_reg  <= PTR_W'(LEAD_START);
                        lag_reg   <= PTR_W'(LAG_START);
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (op == OP_RESEED)
                        begin
                            lcg_reg      <= seed_reg;
                            fill_idx_reg <= '0;
                            state_reg    <= S_FILL;
                        end
                        else
                        begin
                            state_reg <= S_CALC;
                        end
                    end
                end
                S_CALC:
                begin
                    lead_reg <= lead_down;
                    lag_reg  <= lag_down;
                    if (limit_reg == '0)
                    begin
                        state_reg <= S_HOLD;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Hold payload of the item in flight and of the output word
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            limit_reg <= limit;
        end
        if (state_reg == S_CALC)
        begin
            word_reg <= word_calc;
            red_reg  <= word_calc;
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            red_reg <= div_rem;
        end
        if ((state_reg == S_HOLD) && out_free)
        begin
            random_word_reg <= word_reg;
            reduced_reg     <= red_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign random_word = random_word_reg;
    assign fraction    = random_word_reg[DATA_W-1:DATA_W-FRAC_W];
    assign reduced     = reduced_reg;

    // Pointers stay inside the ring
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (lead_reg <= PTR_LAST) && (lag_reg <= PTR_LAST))
        else $error("ring pointer out of range");

    // Lag pointer trails the lead pointer by a fixed distance
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) ||
        ((int'(lead_reg) + LAG_START >= RING_DEPTH) ?
            (int'(lag_reg) == int'(lead_reg) + LAG_START - RING_DEPTH) :
            (int'(lag_reg) == int'(lead_reg) + LAG_START)))
        else $error("ring pointers out of step");

    // A new output word only follows a finished draw
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_HOLD))
        else $error("output word without a finished draw");

    // A refill item starts the ring walk
    a_reseed: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (op == OP_RESEED)) |=> (state_reg == S_FILL) && (fill_idx_reg == '0))
        else $error("refill did not start");

endmodule
